>>> design/dsc_pkg.sv
`default_nettype none
package dsc_pkg;

   // width of the tick countdown
   localparam int TICK_COUNT_BITS = 16;

   // largest count, kept wide so it can be compared with a 16-bit register
   localparam logic [32:0] TICK_MAX_WIDE = (33'd1 << TICK_COUNT_BITS) - 33'd1;

   localparam int REQ_DATA_BITS = 24;
   localparam int RSP_DATA_BITS = 16;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS = 16;
   localparam logic [3:0] RINGS_SAT = 4'd15;

   // configuration register indexes
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_RANGE_LOW     = 3'd0,
      CSR_RANGE_HIGH    = 3'd1,
      CSR_RING_TICKS    = 3'd2,
      CSR_WAIT_TICKS    = 3'd3,
      CSR_BACKOFF_TICKS = 3'd4,
      CSR_MAX_RINGS     = 3'd5
   } csr_index_type;

   // sequencer phases, codes as seen on the result
   typedef enum logic [2:0] {
      PH_SCAN    = 3'd0,
      PH_MEASURE = 3'd1,
      PH_RING    = 3'd2,
      PH_HELD    = 3'd3,
      PH_WAIT    = 3'd4,
      PH_BACKOFF = 3'd5,
      PH_FAULT   = 3'd6
   } phase_type;

   typedef struct packed {
      logic [15:0] range_low;
      logic [15:0] range_high;
      logic [15:0] ring_ticks;
      logic [15:0] wait_ticks;
      logic [15:0] backoff_ticks;
      logic [3:0]  max_rings;
   } cfg_type;

   typedef struct packed {
      logic        door_is_open;
      logic        distance_ok;
      logic [15:0] distance;
      logic        motion_seen;
   } item_type;

   typedef struct packed {
      logic [3:0] rings_used;
      logic       fault;
      logic [2:0] phase_code;
      logic       bell_on;
   } result_type;

   // timer load value, saturating to the countdown range
   function automatic logic [TICK_COUNT_BITS-1:0] load_count(input logic [15:0] ticks);
      logic [32:0] wide;
      wide = 33'(ticks);
      if (wide > TICK_MAX_WIDE) begin
         return TICK_COUNT_BITS'(TICK_MAX_WIDE);
      end
      return TICK_COUNT_BITS'(wide);
   endfunction

endpackage
`default_nettype wire

>>> design/dsc_csr.sv
`default_nettype none
module dsc_csr (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_valid,
   input  wire logic [dsc_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  wire logic [dsc_pkg::CSR_DATA_BITS-1:0]   csr_data,
   output dsc_pkg::cfg_type                         cfg
);

   dsc_pkg::cfg_type cfg_ff;
   dsc_pkg::cfg_type cfg_in;

   // register write decode, unknown indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (dsc_pkg::csr_index_type'(csr_index))
            dsc_pkg::CSR_RANGE_LOW:     cfg_in.range_low = csr_data;
            dsc_pkg::CSR_RANGE_HIGH:    cfg_in.range_high = csr_data;
            dsc_pkg::CSR_RING_TICKS:    cfg_in.ring_ticks = csr_data;
            dsc_pkg::CSR_WAIT_TICKS:    cfg_in.wait_ticks = csr_data;
            dsc_pkg::CSR_BACKOFF_TICKS: cfg_in.backoff_ticks = csr_data;
            dsc_pkg::CSR_MAX_RINGS:     cfg_in.max_rings = csr_data[3:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.range_low     <= 16'd4;
         cfg_ff.range_high    <= 16'd8;
         cfg_ff.ring_ticks    <= 16'd3;
         cfg_ff.wait_ticks    <= 16'd30;
         cfg_ff.backoff_ticks <= 16'(10 * 60);
         cfg_ff.max_rings     <= 4'd3;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

>>> design/dsc_fsm.sv
`default_nettype none
module dsc_fsm (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 step,
   input  wire dsc_pkg::item_type    item,
   input  wire dsc_pkg::cfg_type     cfg,
   output dsc_pkg::result_type       result
);

   dsc_pkg::phase_type                    phase_ff, phase_in;
   logic [dsc_pkg::TICK_COUNT_BITS-1:0]   count_ff, count_in;
   logic [3:0]                            rings_ff, rings_in;

   logic       expired;
   logic       in_window;
   logic [3:0] rings_inc;

   // shared timer check: phase ends when the count is one or less
   assign expired = (count_ff <= dsc_pkg::TICK_COUNT_BITS'(1));
   assign in_window = (item.distance >= cfg.range_low) &&
                      (item.distance <= cfg.range_high);
   assign rings_inc = (rings_ff < dsc_pkg::RINGS_SAT) ? rings_ff + 4'd1 : rings_ff;

   // next phase, timer and retry count for one beat
   always_comb begin
      phase_in = phase_ff;
      count_in = count_ff;
      rings_in = rings_ff;
      unique case (phase_ff)
         dsc_pkg::PH_SCAN: begin
            if (item.motion_seen) phase_in = dsc_pkg::PH_MEASURE;
         end
         dsc_pkg::PH_MEASURE: begin
            if (!item.distance_ok) begin
               phase_in = dsc_pkg::PH_FAULT;
               count_in = '0;
            end else if (in_window) begin
               rings_in = '0;
               phase_in = dsc_pkg::PH_RING;
               count_in = dsc_pkg::load_count(cfg.ring_ticks);
            end else begin
               phase_in = dsc_pkg::PH_SCAN;
            end
         end
         dsc_pkg::PH_RING: begin
            if (expired) begin
               count_in = '0;
               if (item.door_is_open) begin
                  phase_in = dsc_pkg::PH_HELD;
               end else begin
                  phase_in = dsc_pkg::PH_WAIT;
                  count_in = dsc_pkg::load_count(cfg.wait_ticks);
               end
            end else begin
               count_in = count_ff - dsc_pkg::TICK_COUNT_BITS'(1);
            end
         end
         dsc_pkg::PH_HELD: begin
            if (!item.door_is_open) phase_in = dsc_pkg::PH_SCAN;
         end
         dsc_pkg::PH_WAIT: begin
            if (expired) begin
               rings_in = rings_inc;
               if (rings_inc >= cfg.max_rings) begin
                  phase_in = dsc_pkg::PH_BACKOFF;
                  count_in = dsc_pkg::load_count(cfg.backoff_ticks);
               end else begin
                  phase_in = dsc_pkg::PH_RING;
                  count_in = dsc_pkg::load_count(cfg.ring_ticks);
               end
            end else begin
               count_in = count_ff - dsc_pkg::TICK_COUNT_BITS'(1);
            end
         end
         dsc_pkg::PH_BACKOFF: begin
            if (expired) begin
               count_in = '0;
               phase_in = dsc_pkg::PH_SCAN;
            end else begin
               count_in = count_ff - dsc_pkg::TICK_COUNT_BITS'(1);
            end
         end
         dsc_pkg::PH_FAULT: ;
         default: begin
            phase_in = dsc_pkg::PH_SCAN;
            count_in = '0;
         end
      endcase
   end

   // state advances only when a beat moves to the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= dsc_pkg::PH_SCAN;
         count_ff <= '0;
         rings_ff <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         rings_ff <= rings_in;
      end
   end

   // result describes the state after the beat
   assign result.bell_on    = (phase_in == dsc_pkg::PH_RING);
   assign result.phase_code = phase_in;
   assign result.fault      = (phase_in == dsc_pkg::PH_FAULT);
   assign result.rings_used = rings_in;

endmodule
`default_nettype wire

>>> design/doorbell_sequence_controller.sv
// an accepted request beat passes the input register, then the result register, to its response beat
// throughput: one beat per cycle while the response side is not stalled, set by the phase update
// between the input register and the result register
// reset: synchronous, active high; phase scan, timer and retry count zero,
// configuration registers back to their defaults, both channels empty
`default_nettype none
module doorbell_sequence_controller (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output      logic                                req_tready,
   // motion_seen[0], distance[16:1], distance_ok[17], door_is_open[18], zero fill
   input  wire logic [dsc_pkg::REQ_DATA_BITS-1:0]   req_tdata,
   output      logic                                rsp_tvalid,
   input  wire logic                                rsp_tready,
   // bell_on[0], phase_code[3:1], fault[4], rings_used[8:5], zero fill
   output      logic [dsc_pkg::RSP_DATA_BITS-1:0]   rsp_tdata,
   input  wire logic                                csr_valid,
   output      logic                                csr_ready,
   input  wire logic [dsc_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  wire logic [dsc_pkg::CSR_DATA_BITS-1:0]   csr_data
);

   dsc_pkg::cfg_type    cfg;
   dsc_pkg::item_type   item_ff;
   dsc_pkg::result_type result;
   dsc_pkg::result_type rsp_ff;
   logic                in_valid_ff;
   logic                rsp_valid_ff;
   logic                out_free;
   logic                step;

   assign csr_ready = 1'b1;

   dsc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // pipeline control
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign step       = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         item_ff <= dsc_pkg::item_type'(req_tdata[18:0]);
      end
   end

   dsc_fsm u_fsm (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .item   (item_ff),
      .cfg    (cfg),
      .result (result)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_ff};

endmodule
`default_nettype wire
